// ===== hdl/gmg_pkg.sv =====
// gmg_pkg: shared types and constants of the greedy meshlet grouping block
// used by the vertex set cells, the placement logic and the top level
package gmg_pkg;

  localparam int ID_W       = 32;
  localparam int VLIM_W     = 8;
  localparam int TLIM_W     = 10;
  localparam int CFG_W      = 32;
  localparam int GROUP_SIZE = 16;   // cells per registered hit group

  localparam logic [VLIM_W-1:0] VLIM_RESET = 8'd64;
  localparam logic [TLIM_W-1:0] TLIM_RESET = 10'd124;

  typedef enum logic {
    REG_VERTEX_LIMIT   = 1'b0,
    REG_TRIANGLE_LIMIT = 1'b1
  } reg_idx_e;

  // update command for the row of set cells
  typedef struct packed {
    logic       en;         // a triangle commits this cycle
    logic       clear_old;  // new meshlet: entries held so far drop out
    logic       clear_all;  // end of mesh: whole set empties
    logic [1:0] shift;      // number of ids entering at the head
  } cell_ctrl_t;

  // what the compare stage knows about the triangle under placement
  typedef struct packed {
    logic [2:0] hit;    // id k found in the set as it stood at compare time
    logic [8:0] match;  // bit 3*k+j: id k equals id j of the previous triangle
    logic [2:0] dup;    // a==b, a==c, b==c
    logic       fwd;    // previous triangle committed after the compare
    logic       last;
  } tri_info_t;

  // effect of the most recently committed triangle
  typedef struct packed {
    logic       split;
    logic       last;
    logic [2:0] ins;    // which of its ids went into the set
  } prev_t;

  typedef struct packed {
    logic       split;
    logic [2:0] ins;
    logic [1:0] count;  // number of ids inserted
  } decision_t;

endpackage

// ===== hdl/gmg_cell.sv =====
// gmg_cell: one entry of the vertex set, shifts from its upstream neighbors
// and compares its id against the three ids of an incoming triangle; uses gmg_pkg
module gmg_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gmg_pkg::cell_ctrl_t                 ctrl_i,
  input  logic [2:0][gmg_pkg::ID_W-1:0]       up_id_i,     // entry 1, 2, 3 places upstream
  input  logic [2:0]                          up_valid_i,
  input  logic [2:0][gmg_pkg::ID_W-1:0]       key_i,
  output logic [gmg_pkg::ID_W-1:0]            id_o,
  output logic                                valid_o,
  output logic [2:0]                          hit_o
);

  logic [gmg_pkg::ID_W-1:0] id_q, id_d;
  logic                     valid_q, valid_d;

  always_comb begin
    id_d    = id_q;
    valid_d = valid_q;
    if (ctrl_i.en) begin
      case (ctrl_i.shift)
        2'd0: begin
          valid_d = valid_q & ~ctrl_i.clear_old;
        end
        2'd1: begin
          id_d    = up_id_i[0];
          valid_d = up_valid_i[0];
        end
        2'd2: begin
          id_d    = up_id_i[1];
          valid_d = up_valid_i[1];
        end
        default: begin
          id_d    = up_id_i[2];
          valid_d = up_valid_i[2];
        end
      endcase
      if (ctrl_i.clear_all) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit_o[k] = valid_q & (id_q == key_i[k]);
    end
  end

  assign id_o    = id_q;
  assign valid_o = valid_q;

endmodule

// ===== hdl/gmg_decide.sv =====
// gmg_decide: placement of one triangle, resolves membership with forwarding,
// applies both limits and works out insertions and next counts; uses gmg_pkg
module gmg_decide #(
  parameter int VERTEX_SET_SIZE    = 128,
  parameter int TRIANGLE_LIMIT_CAP = 512
) (
  input  gmg_pkg::tri_info_t                         tri_i,
  input  gmg_pkg::prev_t                             prev_i,
  input  logic [$clog2(VERTEX_SET_SIZE+1)-1:0]       vcnt_i,
  input  logic [$clog2(TRIANGLE_LIMIT_CAP+1)-1:0]    tcnt_i,
  input  logic [gmg_pkg::ID_W-1:0]                   mnum_i,
  input  logic [gmg_pkg::VLIM_W-1:0]                 vertex_limit_i,
  input  logic [gmg_pkg::TLIM_W-1:0]                 triangle_limit_i,
  output gmg_pkg::decision_t                         dec_o,
  output logic [$clog2(VERTEX_SET_SIZE+1)-1:0]       vcnt_o,
  output logic [$clog2(TRIANGLE_LIMIT_CAP+1)-1:0]    tcnt_o,
  output logic [gmg_pkg::ID_W-1:0]                   group_o
);

  localparam int CW  = $clog2(VERTEX_SET_SIZE + 1);
  localparam int TW  = $clog2(TRIANGLE_LIMIT_CAP + 1);
  localparam int SW0 = $clog2(VERTEX_SET_SIZE + 4);
  localparam int SW  = (SW0 > gmg_pkg::VLIM_W) ? SW0 : gmg_pkg::VLIM_W;
  localparam int LW  = (TW > gmg_pkg::TLIM_W) ? TW : gmg_pkg::TLIM_W;

  logic [2:0]    member;
  logic [2:0]    fresh;
  logic [1:0]    add;
  logic [SW-1:0] vsum, vlim;
  logic [LW-1:0] tlim;
  logic          split;
  logic [CW-1:0] base_v, avail;
  logic [TW-1:0] base_t;
  logic [2:0]    ins;
  logic [1:0]    ins_cnt;

  // set as of the compare, corrected by what the previous triangle did since
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      member[k] = (tri_i.hit[k] & ~(tri_i.fwd & (prev_i.last | prev_i.split)))
                | (tri_i.fwd & ~prev_i.last & (|(tri_i.match[3*k +: 3] & prev_i.ins)));
    end
  end

  assign add = {1'b0, ~member[0]} + {1'b0, ~member[1]} + {1'b0, ~member[2]};

  assign vsum = SW'(vcnt_i) + SW'(add);
  assign vlim = (SW'(vertex_limit_i) < SW'(VERTEX_SET_SIZE)) ? SW'(vertex_limit_i)
                                                             : SW'(VERTEX_SET_SIZE);
  assign tlim = (LW'(triangle_limit_i) < LW'(TRIANGLE_LIMIT_CAP)) ? LW'(triangle_limit_i)
                                                                  : LW'(TRIANGLE_LIMIT_CAP);

  assign split = (LW'(tcnt_i) >= tlim) || (vsum > vlim);

  // a fresh meshlet takes every distinct id; otherwise only missing ones
  assign fresh[0] = split | ~member[0];
  assign fresh[1] = (split | ~member[1]) & ~tri_i.dup[0];
  assign fresh[2] = (split | ~member[2]) & ~tri_i.dup[1] & ~tri_i.dup[2];

  assign base_v = split ? '0 : vcnt_i;
  assign avail  = CW'(VERTEX_SET_SIZE) - base_v;

  assign ins[0] = fresh[0] && (avail > CW'(0));
  assign ins[1] = fresh[1] && (avail > CW'(ins[0]));
  assign ins[2] = fresh[2] && (avail > (CW'(ins[0]) + CW'(ins[1])));

  assign ins_cnt = {1'b0, ins[0]} + {1'b0, ins[1]} + {1'b0, ins[2]};

  assign base_t = split ? '0 : tcnt_i;
  assign tcnt_o = (base_t < TW'(TRIANGLE_LIMIT_CAP)) ? base_t + TW'(1) : base_t;
  assign vcnt_o = base_v + CW'(ins_cnt);

  assign group_o = mnum_i + gmg_pkg::ID_W'(split);

  assign dec_o.split = split;
  assign dec_o.ins   = ins;
  assign dec_o.count = ins_cnt;

endmodule

// ===== hdl/greedy_meshlet_grouping.sv =====
// greedy_meshlet_grouping: an input transfer is registered in the compare stage,
// then placement writes the output register; throughput one triangle per cycle
// while the output is not stalled, set by the placement loop through the row of
// set cells and the vertex/triangle counters
// reset: asynchronous, clears set valid bits, counters, meshlet number and
// pipeline valids; vertex_limit returns to 64 and triangle_limit to 124
module greedy_meshlet_grouping #(
  parameter int VERTEX_SET_SIZE    = 128,
  parameter int TRIANGLE_LIMIT_CAP = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input triangles
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // vertex_a, vertex_b, vertex_c
  input  logic        s_axis_tlast,   // last_triangle
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // group_id, meshlet_total
  output logic        m_axis_tlast,   // is_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ID_W = gmg_pkg::ID_W;
  localparam int GS   = gmg_pkg::GROUP_SIZE;
  localparam int NG   = (VERTEX_SET_SIZE + GS - 1) / GS;
  localparam int CW   = $clog2(VERTEX_SET_SIZE + 1);
  localparam int TW   = $clog2(TRIANGLE_LIMIT_CAP + 1);

  // ---------------------------------------------------------------------------
  // configuration registers, word aligned, only paddr[2] selects
  // ---------------------------------------------------------------------------
  logic [gmg_pkg::VLIM_W-1:0] vlim_q;
  logic [gmg_pkg::TLIM_W-1:0] tlim_q;
  logic                       cfg_wr;
  gmg_pkg::reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = gmg_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlim_q <= gmg_pkg::VLIM_RESET;
      tlim_q <= gmg_pkg::TLIM_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gmg_pkg::REG_VERTEX_LIMIT:   vlim_q <= pwdata[gmg_pkg::VLIM_W-1:0];
        gmg_pkg::REG_TRIANGLE_LIMIT: tlim_q <= pwdata[gmg_pkg::TLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gmg_pkg::REG_VERTEX_LIMIT:   prdata = 32'(vlim_q);
      gmg_pkg::REG_TRIANGLE_LIMIT: prdata = 32'(tlim_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  logic a_valid_q;
  logic out_valid_q;
  logic a_commit;
  logic s_xfer;

  // placement retires whenever the output register is free or being drained
  assign a_commit      = a_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~a_valid_q | a_commit;
  assign s_xfer        = s_axis_tvalid & s_axis_tready;

  logic [2:0][ID_W-1:0] in_id;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_id[k] = s_axis_tdata[ID_W*k +: ID_W];
    end
  end

  // ---------------------------------------------------------------------------
  // vertex set: a row of cells, new ids enter at the head and older entries
  // move down by the number of ids inserted
  // ---------------------------------------------------------------------------
  gmg_pkg::cell_ctrl_t  cell_ctrl;
  logic [ID_W-1:0]      cell_id    [VERTEX_SET_SIZE];
  logic                 cell_valid [VERTEX_SET_SIZE];
  logic [2:0]           cell_hit   [VERTEX_SET_SIZE];
  logic [ID_W-1:0]      ext_id     [VERTEX_SET_SIZE+3];
  logic                 ext_valid  [VERTEX_SET_SIZE+3];
  logic [2:0][ID_W-1:0] new_id;     // inserted ids, compacted

  // head slots hold the ids to insert, the rest mirror the cells
  always_comb begin
    ext_id[0]    = new_id[2];
    ext_id[1]    = new_id[1];
    ext_id[2]    = new_id[0];
    ext_valid[0] = 1'b1;
    ext_valid[1] = 1'b1;
    ext_valid[2] = 1'b1;
    for (int i = 0; i < VERTEX_SET_SIZE; i++) begin
      ext_id[i+3]    = cell_id[i];
      ext_valid[i+3] = cell_valid[i] & ~cell_ctrl.clear_old;
    end
  end

  for (genvar i = 0; i < VERTEX_SET_SIZE; i++) begin : g_cell
    logic [2:0][ID_W-1:0] up_id;
    logic [2:0]           up_valid;

    always_comb begin
      for (int m = 0; m < 3; m++) begin
        up_id[m]    = ext_id[i+2-m];
        up_valid[m] = ext_valid[i+2-m];
      end
    end

    gmg_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .up_id_i    (up_id),
      .up_valid_i (up_valid),
      .key_i      (in_id),
      .id_o       (cell_id[i]),
      .valid_o    (cell_valid[i]),
      .hit_o      (cell_hit[i])
    );
  end

  // first level of the hit tree, one or per group of cells
  logic [NG*GS-1:0] hit_pad [3];
  logic [NG-1:0]    grp_hit [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit_pad[k] = '0;
      for (int i = 0; i < VERTEX_SET_SIZE; i++) begin
        hit_pad[k][i] = cell_hit[i][k];
      end
      for (int g = 0; g < NG; g++) begin
        grp_hit[k][g] = |hit_pad[k][g*GS +: GS];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // compare stage register
  // ---------------------------------------------------------------------------
  logic [2:0][ID_W-1:0] a_id_q;
  logic                 a_last_q;
  logic [NG-1:0]        a_grp_q [3];
  logic [8:0]           a_match_q;
  logic [2:0]           a_dup_q;
  logic                 a_fwd_q;
  logic                 a_valid_d;
  logic [8:0]           match_d;

  // ids of the triangle that commits in this cycle, for forwarding
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        match_d[3*k+j] = (in_id[k] == a_id_q[j]);
      end
    end
  end

  assign a_valid_d = s_xfer | (a_valid_q & ~a_commit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      a_id_q    <= in_id;
      a_last_q  <= s_axis_tlast;
      a_grp_q   <= grp_hit;
      a_match_q <= match_d;
      a_dup_q   <= {in_id[1] == in_id[2], in_id[0] == in_id[2], in_id[0] == in_id[1]};
      // loading means the stage was empty or is retiring right now
      a_fwd_q   <= a_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // placement
  // ---------------------------------------------------------------------------
  gmg_pkg::tri_info_t tri_info;
  gmg_pkg::prev_t     prev_q;
  gmg_pkg::decision_t dec;
  logic [CW-1:0]      vcnt_q, vcnt_next;
  logic [TW-1:0]      tcnt_q, tcnt_next;
  logic [ID_W-1:0]    mnum_q, group_id;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tri_info.hit[k] = |a_grp_q[k];
    end
    tri_info.match = a_match_q;
    tri_info.dup   = a_dup_q;
    tri_info.fwd   = a_fwd_q;
    tri_info.last  = a_last_q;
  end

  gmg_decide #(
    .VERTEX_SET_SIZE    (VERTEX_SET_SIZE),
    .TRIANGLE_LIMIT_CAP (TRIANGLE_LIMIT_CAP)
  ) u_decide (
    .tri_i            (tri_info),
    .prev_i           (prev_q),
    .vcnt_i           (vcnt_q),
    .tcnt_i           (tcnt_q),
    .mnum_i           (mnum_q),
    .vertex_limit_i   (vlim_q),
    .triangle_limit_i (tlim_q),
    .dec_o            (dec),
    .vcnt_o           (vcnt_next),
    .tcnt_o           (tcnt_next),
    .group_o          (group_id)
  );

  // compact the inserted ids: first, second, third in triangle order
  always_comb begin
    if (dec.ins[0]) begin
      new_id[0] = a_id_q[0];
    end else if (dec.ins[1]) begin
      new_id[0] = a_id_q[1];
    end else begin
      new_id[0] = a_id_q[2];
    end
    new_id[1] = (dec.ins[0] & dec.ins[1]) ? a_id_q[1] : a_id_q[2];
    new_id[2] = a_id_q[2];
  end

  assign cell_ctrl.en        = a_commit;
  assign cell_ctrl.clear_old = dec.split;
  assign cell_ctrl.clear_all = a_last_q;
  assign cell_ctrl.shift     = dec.count;

  // end of mesh puts counts and meshlet number back to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
      tcnt_q <= '0;
      mnum_q <= '0;
      prev_q <= '0;
    end else if (a_commit) begin
      vcnt_q       <= a_last_q ? '0 : vcnt_next;
      tcnt_q       <= a_last_q ? '0 : tcnt_next;
      mnum_q       <= a_last_q ? '0 : group_id;
      prev_q.split <= dec.split;
      prev_q.last  <= a_last_q;
      prev_q.ins   <= dec.ins;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0] out_group_q, out_total_q;
  logic            out_last_q;
  logic            out_valid_d;

  assign out_valid_d = a_commit | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_commit) begin
      out_group_q <= group_id;
      out_last_q  <= a_last_q;
      out_total_q <= a_last_q ? group_id + ID_W'(1) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_total_q, out_group_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/gmg_checker.sv =====
// gmg_checker: port-level checks of greedy_meshlet_grouping over time
// attached to the top level by the bind statement at the end of this file
module gmg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // total is only carried on the last triangle
  a_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[63:32] == 32'd0)
    else $error("meshlet total set on a non-last triangle");

  // the total counts the meshlet of the last triangle itself
  a_total_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[63:32] == m_axis_tdata[31:0] + 32'd1)
    else $error("meshlet total does not follow the last group id");

  // vertex limit reads back what was written
  a_vlim_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2] |=>
      paddr[2] || prdata[7:0] == $past(pwdata[7:0]))
    else $error("vertex limit readback mismatch");

endmodule

bind greedy_meshlet_grouping gmg_checker u_gmg_checker (.*);

// ===== bench/greedy_meshlet_grouping_test.sv =====
// greedy_meshlet_grouping_test: self-checking bench for the greedy meshlet grouping block
// holds its own meshlet placement predictor, drives triangle streams and limit register writes
// depends on gmg_pkg and greedy_meshlet_grouping from the hdl folder
module greedy_meshlet_grouping_test;

  localparam int VSET      = 128;     // vertex set size of the instance
  localparam int TCAP      = 512;     // triangle limit cap of the instance
  localparam int MAX_CYCLE = 250000;  // run limit, several times the slowest correct run

  // one expected result transfer
  typedef struct packed {
    logic [gmg_pkg::ID_W-1:0] group_id;
    logic                     is_last;
    logic [gmg_pkg::ID_W-1:0] meshlet_total;
  } grouping_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;    // vertex_a, vertex_b, vertex_c
  logic        s_axis_tlast = 1'b0;  // last_triangle
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // group_id, meshlet_total
  logic        m_axis_tlast;         // is_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: limit registers and the current meshlet
  logic [gmg_pkg::VLIM_W-1:0] lim_vertex = gmg_pkg::VLIM_RESET;
  logic [gmg_pkg::TLIM_W-1:0] lim_triangle = gmg_pkg::TLIM_RESET;
  logic [gmg_pkg::ID_W-1:0]   held_ids[$];  // distinct ids of the current meshlet, in insert order
  int                         tri_count = 0;
  logic [gmg_pkg::ID_W-1:0]   meshlet_no = '0;

  grouping_t expected_groups[$];       // results still owed by the block, oldest first
  int        errors = 0;
  int        cycles = 0;
  int        src_max_gap = 16;         // longest idle stretch before a triangle transfer
  int        sink_max_gap = 16;        // longest stall before a result transfer
  int        sink_hold = 0;            // one-off long stall requested by the pressure test

  greedy_meshlet_grouping #(
    .VERTEX_SET_SIZE   (VSET),
    .TRIANGLE_LIMIT_CAP(TCAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLE) begin
      $display("[greedy_meshlet_grouping] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit in_meshlet(input logic [gmg_pkg::ID_W-1:0] id);
    foreach (held_ids[i]) begin
      if (held_ids[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // places one triangle and returns the result it must produce
  function automatic grouping_t place_triangle(input logic [2:0][gmg_pkg::ID_W-1:0] ids,
                                               input logic last);
    int        vlim;
    int        tlim;
    int        fresh;
    grouping_t res;
    // limits above the set size or the cap behave as the set size or the cap
    vlim  = (int'(lim_vertex) < VSET) ? int'(lim_vertex) : VSET;
    tlim  = (int'(lim_triangle) < TCAP) ? int'(lim_triangle) : TCAP;
    // a new id repeated inside the triangle is counted once per occurrence
    fresh = 0;
    for (int k = 0; k < 3; k++) begin
      if (!in_meshlet(ids[k])) fresh++;
    end
    // open a new meshlet; a fresh one always takes the whole triangle
    if (tri_count >= tlim || held_ids.size() + fresh > vlim) begin
      meshlet_no = meshlet_no + 1'b1;
      tri_count  = 0;
      held_ids.delete();
    end
    res.group_id      = meshlet_no;
    res.is_last       = last;
    res.meshlet_total = last ? meshlet_no + 1'b1 : '0;
    if (tri_count < TCAP) tri_count++;
    for (int k = 0; k < 3; k++) begin
      if (!in_meshlet(ids[k]) && held_ids.size() < VSET) held_ids.push_back(ids[k]);
    end
    // end of mesh: back to the reset state, limits kept
    if (last) begin
      held_ids.delete();
      tri_count  = 0;
      meshlet_no = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold on request, and the checker
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = $urandom_range(0, sink_max_gap);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
    end
  end

  // every result transfer is matched against the oldest expectation
  always @(posedge clk_i) begin : result_check
    grouping_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (expected_groups.size() == 0) begin
        $error("unexpected result transfer: group_id %0d", m_axis_tdata[31:0]);
        errors++;
      end else begin
        want = expected_groups.pop_front();
        if (m_axis_tdata[31:0] !== want.group_id) begin
          $error("group_id mismatch: expected %0d, actual %0d",
                 want.group_id, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $error("is_last mismatch: expected %0b, actual %0b", want.is_last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[63:32] !== want.meshlet_total) begin
          $error("meshlet_total mismatch: expected %0d, actual %0d",
                 want.meshlet_total, m_axis_tdata[63:32]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one triangle transfer; the prediction is made at the accepting edge
  task automatic send_triangle(input logic [gmg_pkg::ID_W-1:0] a,
                               input logic [gmg_pkg::ID_W-1:0] b,
                               input logic [gmg_pkg::ID_W-1:0] c, input logic last);
    int gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_groups.push_back(place_triangle({c, b, a}, last));
  endtask

  // stop offering triangles and wait until every owed result has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk_i);
  endtask

  // one register transfer, starting from idle; the access edge is the one with penable high
  task automatic cfg_access(input gmg_pkg::reg_idx_e idx, input logic wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // read back a limit register and compare with the predictor's copy
  task automatic check_limit(input gmg_pkg::reg_idx_e idx);
    logic [31:0] rdata;
    cfg_access(idx, 1'b0, '0, rdata);
    if (idx == gmg_pkg::REG_VERTEX_LIMIT && rdata[gmg_pkg::VLIM_W-1:0] !== lim_vertex) begin
      $error("vertex_limit mismatch: expected %0d, actual %0d",
             lim_vertex, rdata[gmg_pkg::VLIM_W-1:0]);
      errors++;
    end
    if (idx == gmg_pkg::REG_TRIANGLE_LIMIT &&
        rdata[gmg_pkg::TLIM_W-1:0] !== lim_triangle) begin
      $error("triangle_limit mismatch: expected %0d, actual %0d",
             lim_triangle, rdata[gmg_pkg::TLIM_W-1:0]);
      errors++;
    end
  endtask

  // write both limits while the block is idle, then read them back
  task automatic set_limits(input int vlim, input int tlim);
    logic [31:0] unused;
    cfg_access(gmg_pkg::REG_VERTEX_LIMIT, 1'b1, vlim, unused);
    lim_vertex = vlim[gmg_pkg::VLIM_W-1:0];
    cfg_access(gmg_pkg::REG_TRIANGLE_LIMIT, 1'b1, tlim, unused);
    lim_triangle = tlim[gmg_pkg::TLIM_W-1:0];
    check_limit(gmg_pkg::REG_VERTEX_LIMIT);
    check_limit(gmg_pkg::REG_TRIANGLE_LIMIT);
  endtask

  // one mesh of random triangles; ids come from a pool so that hits and repeats are common
  task automatic send_mesh(input int n_tri, input int pool, input bit close_mesh);
    logic [gmg_pkg::ID_W-1:0] base;
    logic [gmg_pkg::ID_W-1:0] v[3];
    base = $urandom;
    for (int i = 0; i < n_tri; i++) begin
      for (int k = 0; k < 3; k++) begin
        // a stray full-range id now and then, or everywhere when the pool is open
        if (pool == 0 || $urandom_range(0, 15) == 0) v[k] = $urandom;
        else v[k] = base + $urandom_range(0, pool - 1);
      end
      send_triangle(v[0], v[1], v[2], close_mesh && i == n_tri - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset limits, id extremes, a new id repeated inside one triangle, end of mesh
  task automatic test_reset_defaults();
    check_limit(gmg_pkg::REG_VERTEX_LIMIT);
    check_limit(gmg_pkg::REG_TRIANGLE_LIMIT);
    send_triangle('0, '0, '0, 1'b0);
    send_triangle('1, '1, '0, 1'b0);
    send_triangle(32'd1, 32'd2, '1, 1'b1);
    // mesh restarted: same ids count as new again
    send_triangle('1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    drain_results();
  endtask

  // zero limits: every triangle splits, meshlet 0 stays empty
  task automatic test_zero_limits();
    set_limits(0, 0);
    send_triangle(32'd5, 32'd6, 32'd7, 1'b0);
    send_triangle(32'd5, 32'd6, 32'd7, 1'b1);
    drain_results();
    // zero vertex limit only: every triangle splits, as the held ids already exceed the limit
    set_limits(0, 124);
    send_triangle(32'd5, 32'd6, 32'd7, 1'b0);
    send_triangle(32'd7, 32'd5, 32'd6, 1'b0);
    send_triangle(32'd5, 32'd6, 32'd8, 1'b1);
    drain_results();
  endtask

  // a fresh meshlet takes the whole triangle even above a tiny vertex limit
  task automatic test_small_vertex_limit();
    set_limits(1, 512);
    send_triangle(32'd10, 32'd11, 32'd12, 1'b0);
    send_triangle(32'd12, 32'd11, 32'd10, 1'b0);
    send_triangle(32'd10, 32'd11, 32'd13, 1'b1);
    drain_results();
  endtask

  // triangle limit reached, including a limit of one
  task automatic test_triangle_limit();
    set_limits(128, 1);
    send_triangle(32'd1, 32'd2, 32'd3, 1'b0);
    send_triangle(32'd1, 32'd2, 32'd3, 1'b0);
    send_triangle(32'd4, 32'd5, 32'd6, 1'b1);
    drain_results();
    set_limits(128, 2);
    repeat (2) send_triangle(32'd1, 32'd2, 32'd3, 1'b0);
    send_triangle(32'd1, 32'd2, 32'd3, 1'b1);
    drain_results();
  endtask

  // register values above the set size and the cap
  task automatic test_limits_above_cap();
    set_limits(255, 1023);
    send_triangle(32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
    send_triangle(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFE, 1'b1);
    drain_results();
  endtask

  // random meshes over a series of limit settings, with and without idling
  task automatic test_random_meshes();
    int phase_vlim[8] = '{128, 1, 3, 64, 128, 16, 255, 0};
    int phase_tlim[8] = '{512, 1, 4, 124, 8, 512, 1023, 0};
    int pools[4] = '{3, 8, 40, 300};
    int sent;
    int n_tri;
    for (int p = 0; p < 8; p++) begin
      // last phase draws its limits at random
      if (p == 7) set_limits($urandom_range(1, 128), $urandom_range(1, 512));
      else set_limits(phase_vlim[p], phase_tlim[p]);
      src_max_gap  = (p % 3 == 1) ? 0 : 16;
      sink_max_gap = (p % 4 == 3) ? 0 : 16;
      sent = 0;
      while (sent < 70) begin
        n_tri = $urandom_range(1, 80);
        // most meshes well formed; some open pools, some runs left without an end
        send_mesh(n_tri, ($urandom_range(0, 7) == 0) ? 0 : pools[$urandom_range(0, 3)],
                  $urandom_range(0, 7) != 0);
        sent += n_tri;
      end
      drain_results();
    end
    src_max_gap  = 16;
    sink_max_gap = 16;
  endtask

  // results held back for a long stretch while triangles keep coming
  task automatic test_backpressure();
    set_limits(16, 20);
    src_max_gap = 0;
    sink_hold   = 300;
    send_mesh(48, 40, 1'b1);
    drain_results();
    src_max_gap = 16;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_limits();
    test_small_vertex_limit();
    test_triangle_limit();
    test_limits_above_cap();
    test_random_meshes();
    test_backpressure();
    drain_results();
    // let any stray result surface before the verdict
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[greedy_meshlet_grouping] OK");
    end else begin
      $display("[greedy_meshlet_grouping] ERROR");
    end
    $finish;
  end

endmodule

// ===== greedy_meshlet_grouping.f =====
hdl/gmg_pkg.sv
hdl/gmg_cell.sv
hdl/gmg_decide.sv
hdl/greedy_meshlet_grouping.sv
hdl/gmg_checker.sv
bench/greedy_meshlet_grouping_test.sv
